/* sv/sps_pkg.sv */
package sps_pkg;

  localparam int unsigned PlanDepth  = 8;
  localparam int unsigned CodeBits   = 3;
  localparam int unsigned PlanBits   = PlanDepth * CodeBits;
  localparam int unsigned IdxBits    = 3;
  localparam int unsigned LenBits    = 4;
  localparam int unsigned DwellBits  = 16;
  localparam int unsigned TimerBits  = 16;
  localparam int unsigned CmpBits    = (TimerBits > DwellBits) ? TimerBits : DwellBits;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgBits    = 24;

  typedef logic [TimerBits-1:0] timer_t;
  typedef logic [DwellBits-1:0] dwell_t;

  typedef enum logic [CodeBits-1:0] {
    MsLane   = 3'd0,
    MsRight  = 3'd1,
    MsCones  = 3'd2,
    MsGate   = 3'd3,
    MsCross  = 3'd4,
    MsRotary = 3'd5,
    MsColour = 3'd6
  } mission_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgStagePlan     = 3'd0,
    CfgPlanLength    = 3'd1,
    CfgDwellTicks    = 3'd2,
    CfgCrossDwell    = 3'd3,
    CfgBiasTicks     = 3'd4,
    CfgBiasPixels    = 3'd5
  } cfg_idx_e;

  localparam logic [PlanBits-1:0] StagePlanRst  = 24'd6902438;
  localparam logic [LenBits-1:0]  PlanLengthRst = 4'd8;
  localparam dwell_t              DwellRst      = 16'd15;
  localparam dwell_t              CrossDwellRst = 16'd90;
  localparam dwell_t              BiasTicksRst  = 16'd240;
  localparam logic signed [7:0]   BiasPixRst    = 8'sd30;

  typedef struct packed {
    logic              cone_seen;
    logic              gate_seen;
    logic              crosswalk_seen;
    logic              rotary_seen;
    logic signed [7:0] color_level;
  } in_t;

  typedef struct packed {
    mission_e          mission;
    logic [2:0]        stage_number;
    logic              stage_running;
    logic signed [7:0] lane_bias;
    logic [1:0]        lane_color;
  } out_t;

endpackage

/* sv/stage_plan_sequencer.sv */
// Mission stage sequencer. Each input transaction is one control tick and yields exactly one
// result transaction. The block walks a plan of up to eight 3-bit mission codes: a detected
// stage starts on the tick its detector fires and ends once the detection is clear and its
// dwell (a separate one for crosswalk) has elapsed; a right-bias stage starts at once, drives
// bias_pixels on lane_bias and ends after bias_ticks. The last stage of the plan is held.
// Throughput is one tick per clock; the stage state and result register update in the same
// cycle the tick is taken, and the only stall is a full result register not yet taken.
// Configuration is written on cfg_we_i / cfg_idx_i / cfg_data_i, by the user only while
// no tick is in flight (the block does not enforce this); indexes 6 and 7 are ignored.
module stage_plan_sequencer
  import sps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [CfgBits-1:0]    cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_t                  out_data_o
);

  localparam timer_t TimerMax = '1;

  // configuration registers
  logic [PlanBits-1:0] plan_q;
  logic [LenBits-1:0]  len_q;
  dwell_t              dwell_q;
  dwell_t              cross_dwell_q;
  dwell_t              bias_ticks_q;
  logic signed [7:0]   bias_pix_q;

  // stage state
  logic [IdxBits-1:0] idx_q, idx_d;
  logic               active_q, active_d;
  timer_t             elapsed_q, elapsed_d;

  logic out_valid_q;
  out_t out_q, out_d;

  logic               take;
  logic [1:0]         color;
  mission_e           target;
  mission_e           mission;
  logic               det;
  logic               finish;
  timer_t             elapsed_inc;
  dwell_t             dwell_sel;
  logic [LenBits-1:0] eff_len;
  logic [4:0]         plan_pos;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plan_q        <= StagePlanRst;
      len_q         <= PlanLengthRst;
      dwell_q       <= DwellRst;
      cross_dwell_q <= CrossDwellRst;
      bias_ticks_q  <= BiasTicksRst;
      bias_pix_q    <= BiasPixRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgStagePlan:  plan_q        <= cfg_data_i[PlanBits-1:0];
        CfgPlanLength: len_q         <= cfg_data_i[LenBits-1:0];
        CfgDwellTicks: dwell_q       <= cfg_data_i[DwellBits-1:0];
        CfgCrossDwell: cross_dwell_q <= cfg_data_i[DwellBits-1:0];
        CfgBiasTicks:  bias_ticks_q  <= cfg_data_i[DwellBits-1:0];
        CfgBiasPixels: bias_pix_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // clamp raw colour to none / red / blue
    if (in_data_i.color_level < 0) begin
      color = 2'd0;
    end else if (in_data_i.color_level > 8'sd2) begin
      color = 2'd2;
    end else begin
      color = in_data_i.color_level[1:0];
    end

    if (len_q == '0) begin
      eff_len = LenBits'(1);
    end else if (len_q > LenBits'(PlanDepth)) begin
      eff_len = LenBits'(PlanDepth);
    end else begin
      eff_len = len_q;
    end

    plan_pos    = 5'(idx_q) * 5'd3;
    target      = mission_e'(plan_q[plan_pos +: CodeBits]);
    elapsed_inc = (elapsed_q == TimerMax) ? elapsed_q : elapsed_q + timer_t'(1);
    dwell_sel   = (target == MsCross) ? cross_dwell_q : dwell_q;

    case (target)
      MsColour: det = color != 2'd0;
      MsCross:  det = in_data_i.crosswalk_seen;
      MsCones:  det = in_data_i.cone_seen;
      MsRotary: det = in_data_i.rotary_seen;
      MsGate:   det = in_data_i.gate_seen;
      default:  det = 1'b0;
    endcase

    active_d  = active_q;
    elapsed_d = elapsed_q;
    idx_d     = idx_q;
    finish    = 1'b0;
    mission   = target;

    if (target == MsRight) begin
      if (!active_q) begin
        active_d  = 1'b1;
        elapsed_d = '0;
      end else begin
        elapsed_d = elapsed_inc;
        finish    = CmpBits'(elapsed_inc) >= CmpBits'(bias_ticks_q);
      end
    end else if (!active_q) begin
      if (det) begin
        active_d  = 1'b1;
        elapsed_d = '0;
      end else begin
        mission = MsLane;
      end
    end else begin
      elapsed_d = elapsed_inc;
      finish    = !det && (CmpBits'(elapsed_inc) >= CmpBits'(dwell_sel));
    end

    if (finish) begin
      active_d = 1'b0;
      if ((LenBits'(idx_q) + LenBits'(1)) < eff_len) begin
        idx_d = idx_q + IdxBits'(1);
      end
    end

    out_d.mission       = mission;
    out_d.stage_number  = idx_d;
    out_d.stage_running = active_d;
    out_d.lane_bias     = (target == MsRight && active_d) ? bias_pix_q : 8'sd0;
    out_d.lane_color    = color;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      active_q    <= 1'b0;
      elapsed_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        idx_q     <= idx_d;
        active_q  <= active_d;
        elapsed_q <= elapsed_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= out_d;
    end
  end

endmodule

/* sim/stage_plan_sequencer_tb.sv */
`timescale 1ns / 100ps

module stage_plan_sequencer_tb;
  import sps_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned CalmStart  = 1000;
  localparam int unsigned CalmEnd    = 1600;

  logic                  clk_i      = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx    = CfgStagePlan;
  logic [CfgBits-1:0]    cfg_data   = '0;
  logic                  in_valid   = 1'b0;
  logic                  in_ready_o;
  in_t                   in_data    = '0;
  logic                  out_valid_o;
  logic                  out_ready  = 1'b0;
  out_t                  out_data_o;

  int unsigned cyc    = 0;
  int          errors = 0;
  logic        calm;

  // ticks waiting to be sent, and the results they must produce
  in_t  tick_q[$];
  out_t result_q[$];

  // mirror of the configuration registers
  logic [PlanBits-1:0] plan_r   = StagePlanRst;
  logic [LenBits-1:0]  len_r    = PlanLengthRst;
  dwell_t              dwell_r  = DwellRst;
  dwell_t              xdwell_r = CrossDwellRst;
  dwell_t              bticks_r = BiasTicksRst;
  logic [7:0]          bpix_r   = BiasPixRst;

  // mirror of the stage state
  logic [IdxBits-1:0] stg_idx     = '0;
  logic               stg_on      = 1'b0;
  timer_t             stg_elapsed = '0;

  stage_plan_sequencer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  assign calm = (cyc >= CalmStart) && (cyc < CalmEnd);

  function automatic void bump_timer();
    if (stg_elapsed != {TimerBits{1'b1}}) stg_elapsed = stg_elapsed + 1'b1;
  endfunction

  function automatic void close_stage();
    int eff;
    eff = (len_r == 0) ? 1 : ((len_r > PlanDepth) ? PlanDepth : int'(len_r));
    stg_on = 1'b0;
    if (int'(stg_idx) + 1 < eff) stg_idx = stg_idx + 1'b1;
  endfunction

  function automatic out_t advance_plan(in_t t);
    out_t       r;
    logic [1:0] col;
    logic [2:0] code;
    logic       det;
    mission_e   ms;
    if ($signed(t.color_level) < 0) col = 2'd0;
    else if ($signed(t.color_level) > 2) col = 2'd2;
    else col = t.color_level[1:0];
    code = plan_r[3*int'(stg_idx) +: 3];
    if (code == MsRight) begin
      ms = MsRight;
      if (!stg_on) begin
        stg_on = 1'b1;
        stg_elapsed = '0;
      end else begin
        bump_timer();
        if (stg_elapsed >= bticks_r) close_stage();
      end
    end else begin
      case (code)
        MsColour: det = (col != 2'd0);
        MsCross:  det = t.crosswalk_seen;
        MsCones:  det = t.cone_seen;
        MsRotary: det = t.rotary_seen;
        MsGate:   det = t.gate_seen;
        default:  det = 1'b0;
      endcase
      if (!stg_on) begin
        if (det) begin
          stg_on = 1'b1;
          stg_elapsed = '0;
          ms = mission_e'(code);
        end else begin
          ms = MsLane;
        end
      end else begin
        ms = mission_e'(code);
        bump_timer();
        if (!det && stg_elapsed >= ((code == MsCross) ? xdwell_r : dwell_r)) close_stage();
      end
    end
    r.mission       = ms;
    r.stage_number  = stg_idx;
    r.stage_running = stg_on;
    r.lane_bias     = (code == MsRight && stg_on) ? bpix_r : 8'd0;
    r.lane_color    = col;
    return r;
  endfunction

  function automatic in_t mk_tick(logic [3:0] flags, logic [7:0] level);
    return {flags, level};
  endfunction

  task automatic chk_field(string nm, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, nm, want, got);
      errors++;
    end
  endtask

  task automatic set_reg(cfg_idx_e idx, logic [CfgBits-1:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      CfgStagePlan:  plan_r   = val[PlanBits-1:0];
      CfgPlanLength: len_r    = val[LenBits-1:0];
      CfgDwellTicks: dwell_r  = val[DwellBits-1:0];
      CfgCrossDwell: xdwell_r = val[DwellBits-1:0];
      CfgBiasTicks:  bticks_r = val[DwellBits-1:0];
      CfgBiasPixels: bpix_r   = val[7:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (tick_q.size() != 0 || in_valid || result_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // detector bursts that switch on and off, with stray flags and pure noise mixed in
  task automatic queue_ticks(int n);
    int         left;
    int         len;
    int         k;
    logic       on;
    logic [3:0] f;
    logic [7:0] c;
    left = n;
    on = 1'b0;
    while (left > 0) begin
      len = $urandom_range(1, 10);
      if (len > left) len = left;
      if ($urandom_range(0, 99) < 15) begin
        for (k = 0; k < len; k++) tick_q.push_back(mk_tick(4'($urandom), 8'($urandom)));
      end else begin
        on = ~on;
        for (k = 0; k < len; k++) begin
          f = on ? 4'hf : 4'h0;
          if ($urandom_range(0, 99) < 10) f = f ^ 4'($urandom);
          c = on ? 8'($urandom_range(1, 127)) : 8'(-int'($urandom_range(0, 128)));
          tick_q.push_back(mk_tick(f, c));
        end
      end
      left -= len;
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (in_valid && in_ready_o) result_q.push_back(advance_plan(in_data));
      if (!in_valid || in_ready_o) begin
        if (tick_q.size() != 0 && (calm || $urandom_range(0, 99) >= 15)) begin
          in_data  <= tick_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : mon
    out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 15);
      if (out_valid_o && out_ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, actual %0h",
                   $time, out_data_o);
          errors++;
        end else begin
          want = result_q.pop_front();
          chk_field("mission", 8'(want.mission), 8'(out_data_o.mission));
          chk_field("stage_number", 8'(want.stage_number), 8'(out_data_o.stage_number));
          chk_field("stage_running", 8'(want.stage_running), 8'(out_data_o.stage_running));
          chk_field("lane_bias", 8'(want.lane_bias), 8'(out_data_o.lane_bias));
          chk_field("lane_color", 8'(want.lane_color), 8'(out_data_o.lane_color));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc == CycleLimit) begin
      $display("stage_plan_sequencer test failed");
      $finish;
    end
  end

  initial begin
    int            p;
    int            k;
    int            pos;
    logic [23:0]   plan;
    logic [3:0]    len;
    dwell_t        dw;
    dwell_t        xdw;
    dwell_t        bt;
    logic [7:0]    bp;

    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;

    // reset settings: colour stage first, then crosswalk
    tick_q.push_back(mk_tick(4'h0, 8'h80));
    tick_q.push_back(mk_tick(4'h0, 8'hff));
    tick_q.push_back(mk_tick(4'h0, 8'h00));
    tick_q.push_back(mk_tick(4'hf, 8'h00));
    tick_q.push_back(mk_tick(4'h8, 8'h01));
    tick_q.push_back(mk_tick(4'h4, 8'h02));
    tick_q.push_back(mk_tick(4'h2, 8'h03));
    tick_q.push_back(mk_tick(4'h1, 8'h7f));
    tick_q.push_back(mk_tick(4'hf, 8'h55));
    tick_q.push_back(mk_tick(4'h0, 8'haa));
    // colour clear long enough for the dwell to pass
    for (k = 0; k < 12; k++) tick_q.push_back(mk_tick(4'(k) & 4'b1101, 8'(-k - 1)));
    tick_q.push_back(mk_tick(4'b0010, 8'h00));
    tick_q.push_back(mk_tick(4'b0010, 8'h00));

    for (p = 0; p < 16; p++) begin
      if (p == 8) begin
        // gate held under the longest dwell, then released
        wait_idle();
        pos = stg_idx;
        plan = 24'($urandom);
        plan[3*pos +: 3] = MsGate;
        set_reg(CfgStagePlan, plan);
        set_reg(CfgPlanLength, 24'd1);
        set_reg(CfgDwellTicks, 24'hffff);
        for (k = 0; k < 40; k++) begin
          tick_q.push_back(mk_tick(4'($urandom) | 4'b0100, 8'($urandom)));
        end
        for (k = 0; k < 6; k++) begin
          tick_q.push_back(mk_tick(4'($urandom) & 4'b1011, 8'($urandom)));
        end
      end
      wait_idle();
      pos = stg_idx;
      plan = 24'($urandom);
      // early phases hold one stage and walk its code through every value
      if (p < 8) plan[3*pos +: 3] = 3'(p);
      if (p < 8) len = (p == 3) ? 4'd0 : 4'd1;
      else if (p == 13) len = 4'd15;
      else len = 4'(p - 6);
      dw  = (p == 2) ? 16'd0 : ((p == 5) ? 16'hffff : 16'($urandom_range(0, 6)));
      xdw = (p == 4) ? 16'd0 : ((p == 12) ? 16'hffff : 16'($urandom_range(0, 8)));
      bt  = (p == 1) ? 16'd0 : ((p == 9) ? 16'hffff : 16'($urandom_range(0, 8)));
      bp  = (p == 1) ? 8'h80 : ((p == 9) ? 8'h7f : 8'($urandom));
      set_reg(CfgStagePlan, plan);
      set_reg(CfgPlanLength, {20'($urandom), len});
      set_reg(CfgDwellTicks, {8'($urandom), dw});
      set_reg(CfgCrossDwell, {8'($urandom), xdw});
      set_reg(CfgBiasTicks, {8'($urandom), bt});
      set_reg(CfgBiasPixels, {16'($urandom), bp});
      queue_ticks(120);
    end

    wait_idle();
    repeat (4) @(posedge clk_i);
    if (errors == 0) begin
      $display("stage_plan_sequencer test passed");
    end else begin
      $display("stage_plan_sequencer test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/sps_pkg.sv
sv/stage_plan_sequencer.sv
sim/stage_plan_sequencer_tb.sv
